/* rtl/mfrc_pkg.sv */
// Shared types for the monochrome frame buffer with rectangle clear.
// Holds the operation codes, the controller state type and the
// command and status bundles that join the controller to the datapath.
package mfrc_pkg;

   // Item kinds carried on the input channel's tuser.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_RECT_CHK,
      ST_RECT_BYTE,
      ST_RECT_RMW,
      ST_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init_wr;   // write zero at the clearing-pass address
      logic capture;   // load the accepted item
      logic setup;     // clip the rectangle and load the walk registers
      logic rd_item;   // read the byte at the item address
      logic rd_rect;   // read the current rectangle byte
      logic wr_item;   // write the item byte
      logic wr_zero;   // zero the current rectangle byte
      logic wr_mask;   // write back the masked rectangle byte
      logic advance;   // step to the next rectangle byte
      logic load_rsp;  // load the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic   init_last;  // clearing pass is at its last entry
      op_type op;         // kind of the held item
      logic   addr_ok;    // item address lies inside the buffer
      logic   empty;      // clipped rectangle covers no pixel
      logic   part_byte;  // current rectangle byte is only partly covered
      logic   last_byte;  // current rectangle byte is the final one
      logic   rsp_free;   // output register can take a result this cycle
   } dp_sts_type;

endpackage

/* rtl/mono_framebuffer_rect_clear.sv */
// Monochrome frame buffer with byte read/write and rectangle clear.
// A byte write or read is done in the decode state; a clear walks the covered rows,
// zeroing each fully covered byte at once and reading then masking each partly covered byte.
// One item is in work at a time, and a stalled result holds it.
// Synchronous reset starts a clearing pass that zeroes all DISPLAY_WIDTH/8*DISPLAY_HEIGHT
// bytes (2560 by default), during which req_tready stays low.
module mono_framebuffer_rect_clear #(
   parameter int DISPLAY_WIDTH  = 160,
   parameter int DISPLAY_HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op [1:0]
   input  logic [1:0]  req_tuser,
   // byte_addr [11:0], write_byte [19:12], x_left [27:20], y_top [34:28],
   // x_right [42:35], y_bottom [50:43], zero [55:51]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte [7:0], empty_rect [8], zero [15:9]
   output logic [15:0] rsp_tdata
);
   import mfrc_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   mfrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mfrc_dpath #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The clearing pass keeps the input closed right after reset.
   a_init_closed: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input open during the clearing pass");

   // One item at a time: an input transfer closes the input on the next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input open while an item is in work");

   // A result is only loaded when the output register has room.
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> sts.rsp_free)
      else $error("result loaded over a pending one");

   // The memory write port serves one source per cycle.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_wr, cmd.wr_item, cmd.wr_zero, cmd.wr_mask}))
      else $error("conflicting memory writes");

endmodule

/* rtl/mfrc_ctrl.sv */
// Controller state machine for the frame buffer block.
// Depends on mfrc_pkg for the state type and the command/status bundles.
module mfrc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mfrc_pkg::dp_sts_type sts,
   output mfrc_pkg::dp_cmd_type cmd
);
   import mfrc_pkg::*;

   ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.op)
               OP_WRITE: begin
                  cmd.wr_item = sts.addr_ok;
                  state_in    = ST_DONE;
               end
               OP_READ: begin
                  cmd.rd_item = sts.addr_ok;
                  state_in    = ST_DONE;
               end
               OP_CLEAR: begin
                  cmd.setup = 1'b1;
                  state_in  = ST_RECT_CHK;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_RECT_CHK: begin
            if (sts.empty) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RECT_BYTE;
            end
         end
         ST_RECT_BYTE: begin
            // Partly covered bytes need a read first; inner bytes are zeroed at once.
            if (sts.part_byte) begin
               cmd.rd_rect = 1'b1;
               state_in    = ST_RECT_RMW;
            end else begin
               cmd.wr_zero = 1'b1;
               cmd.advance = 1'b1;
               if (sts.last_byte) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RECT_RMW: begin
            cmd.wr_mask = 1'b1;
            cmd.advance = 1'b1;
            if (sts.last_byte) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_RECT_BYTE;
            end
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

/* rtl/mfrc_dpath.sv */
// Datapath for the frame buffer block: item registers, the byte memory,
// the rectangle walk registers and the output register.
// Depends on mfrc_pkg for the command/status bundles and the op codes.
module mfrc_dpath #(
   parameter int DISPLAY_WIDTH  = 160,
   parameter int DISPLAY_HEIGHT = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_tuser,
   input  logic [55:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   input  mfrc_pkg::dp_cmd_type cmd,
   output mfrc_pkg::dp_sts_type sts
);
   import mfrc_pkg::*;

   localparam int ROW_BYTES  = DISPLAY_WIDTH / 8;
   localparam int ROW_PIXELS = ROW_BYTES * 8;
   localparam int BUF_BYTES  = ROW_BYTES * DISPLAY_HEIGHT;
   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int YW = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;
   localparam logic [AW-1:0] LAST_ADDR   = AW'(BUF_BYTES - 1);
   localparam logic [AW-1:0] ROW_STEP    = AW'(ROW_BYTES);
   localparam logic [10:0]   ROW_PIX_LIM = 11'(ROW_PIXELS);
   localparam logic [10:0]   HEIGHT_LIM  = 11'(DISPLAY_HEIGHT);

   // Held item.
   op_type      op_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wbyte_ff;
   logic [7:0]  xl_ff;
   logic [6:0]  yt_ff;
   logic [7:0]  xr_ff;
   logic [7:0]  yb_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_tuser);
         addr_ff  <= req_tdata[11:0];
         wbyte_ff <= req_tdata[19:12];
         xl_ff    <= req_tdata[27:20];
         yt_ff    <= req_tdata[34:28];
         xr_ff    <= req_tdata[42:35];
         yb_ff    <= req_tdata[50:43];
      end
   end

   logic          addr_ok;
   logic [AW-1:0] item_addr;
   assign addr_ok   = 32'(addr_ff) < BUF_BYTES;
   assign item_addr = AW'(addr_ff);

   // Clipping and edge figures of the held rectangle.
   logic [10:0] xr_c, yb_c, xr_m1;
   logic        empty_in;
   always_comb begin
      xr_c     = ({3'b000, xr_ff} > ROW_PIX_LIM) ? ROW_PIX_LIM : {3'b000, xr_ff};
      yb_c     = ({3'b000, yb_ff} > HEIGHT_LIM) ? HEIGHT_LIM : {3'b000, yb_ff};
      xr_m1    = xr_c - 11'd1;
      empty_in = ({3'b000, xl_ff} >= xr_c) || ({4'b0000, yt_ff} >= yb_c);
   end

   // Rectangle walk registers.
   logic          empty_ff;
   logic [CW-1:0] b0_ff, b1_ff, col_ff;
   logic [2:0]    lo_ff;
   logic [3:0]    hi_ff;
   logic [YW-1:0] y_ff, y_last_ff;
   logic [AW-1:0] row_base_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         empty_ff    <= empty_in;
         b0_ff       <= CW'(xl_ff[7:3]);
         b1_ff       <= CW'(xr_m1[10:3]);
         col_ff      <= CW'(xl_ff[7:3]);
         lo_ff       <= xl_ff[2:0];
         hi_ff       <= {1'b0, xr_m1[2:0]} + 4'd1;
         y_ff        <= YW'(yt_ff);
         y_last_ff   <= YW'(yb_c - 11'd1);
         row_base_ff <= AW'(32'(yt_ff) * ROW_BYTES);
      end else if (cmd.advance) begin
         if (col_ff == b1_ff) begin
            col_ff      <= b0_ff;
            y_ff        <= y_ff + 1'b1;
            row_base_ff <= row_base_ff + ROW_STEP;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // Pixel mask of the current byte column.
   logic [AW-1:0] rect_addr;
   logic [3:0]    lo_eff, hi_eff;
   logic [7:0]    mask;
   always_comb begin
      rect_addr = row_base_ff + AW'(col_ff);
      lo_eff    = (col_ff == b0_ff) ? {1'b0, lo_ff} : 4'd0;
      hi_eff    = (col_ff == b1_ff) ? hi_ff : 4'd8;
      mask      = (8'hFF >> lo_eff) & ~(8'hFF >> hi_eff);
   end

   // Clearing pass counter after reset.
   logic [AW-1:0] init_cnt_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else if (cmd.init_wr) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   // Frame buffer memory: one write port and one registered read port.
   logic [7:0]    mem [0:BUF_BYTES-1];
   logic [7:0]    mem_q_ff;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data;

   always_comb begin
      wr_en   = cmd.init_wr | cmd.wr_item | cmd.wr_zero | cmd.wr_mask;
      rd_en   = cmd.rd_item | cmd.rd_rect;
      rd_addr = cmd.rd_item ? item_addr : rect_addr;
      if (cmd.init_wr) begin
         wr_addr = init_cnt_ff;
         wr_data = 8'h00;
      end else if (cmd.wr_item) begin
         wr_addr = item_addr;
         wr_data = wbyte_ff;
      end else if (cmd.wr_mask) begin
         wr_addr = rect_addr;
         wr_data = mem_q_ff & ~mask;
      end else begin
         wr_addr = rect_addr;
         wr_data = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   // Output register; it frees up in the cycle its transfer completes.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_empty_ff;
   logic       rsp_free;

   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_byte_ff  <= (op_ff == OP_READ && addr_ok) ? mem_q_ff : 8'h00;
         rsp_empty_ff <= (op_ff == OP_CLEAR) ? empty_ff : 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_empty_ff, rsp_byte_ff};

   // Status back to the controller.
   always_comb begin
      sts.init_last = (init_cnt_ff == LAST_ADDR);
      sts.op        = op_ff;
      sts.addr_ok   = addr_ok;
      sts.empty     = empty_ff;
      sts.part_byte = (mask != 8'hFF);
      sts.last_byte = (col_ff == b1_ff) && (y_ff == y_last_ff);
      sts.rsp_free  = rsp_free;
   end

endmodule
